FILE: design/blcc_pkg.sv
package blcc_pkg;

  localparam int unsigned LINE_NUM_W   = 16;
  localparam int unsigned BODY_LEN_W   = 16;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned ERR_W        = 3;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned OUT_DATA_W   = 24;

  localparam logic [LINE_NUM_W-1:0] MAX_LINE_DEFAULT = 16'd9999;
  localparam logic [7:0]            LINE_END         = 8'h0d;

  localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_NUMBER = 3'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_LEN   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_TERM    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_SHORT_HDR  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_SHORT_BODY = 3'd5;
  localparam logic [ERR_W-1:0] ERR_EMPTY      = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;
  } item_t;

  typedef struct packed {
    logic                 valid_res;
    logic [ERR_W-1:0]     error_kind;
    logic [COUNT_W-1:0]   line_count;
  } result_t;

endpackage

FILE: design/basic_line_chain_checker_top.sv
// Checks a byte stream, one byte per transfer, for a well-formed chain of
// tokenised BASIC line records (big-endian line number, little-endian body
// length, body ending in 0x0d). One byte is taken every cycle; the only
// stall comes from m_tready held low while a result is waiting. The verdict
// for a stream is registered in the result register once the transfer that
// carries tlast has passed the input register, and is held until m_tready.
// tuser marks a transfer without a data byte (meant for an empty stream).
// The user must write max_line_number through cfg_wr_en/cfg_wr_data only
// between streams; the block itself does not enforce this.
module basic_line_chain_checker_top
  import blcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LINE_NUM_W-1:0] cfg_wr_data,   // max_line_number
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,       // [7:0] data_byte
  input  logic                  s_tlast,       // last_byte
  input  logic                  s_tuser,       // no_data
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata        // [0] valid_res, [3:1] error_kind,
                                               // [19:4] line_count, [23:20] zero
);

  logic [LINE_NUM_W-1:0] max_line_number;
  item_t                 s_item;
  item_t                 item;
  logic                  item_valid;
  logic                  advance;
  result_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_number <= MAX_LINE_DEFAULT;
    end else if (cfg_wr_en) begin
      max_line_number <= cfg_wr_data;
    end
  end

  assign s_item.data_byte = s_tdata;
  assign s_item.last_byte = s_tlast;
  assign s_item.no_data   = s_tuser;

  blcc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  blcc_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .max_line_number (max_line_number),
    .item_valid      (item_valid),
    .item            (item),
    .advance         (advance),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .res             (res)
  );

  assign m_tdata = {4'b0000, res.line_count, res.error_kind, res.valid_res};

endmodule

FILE: design/blcc_in_reg.sv
module blcc_in_reg
  import blcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  // stage accepts a new item when empty or when the next stage advances
  assign s_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

FILE: design/blcc_parser.sv
module blcc_parser
  import blcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [LINE_NUM_W-1:0] max_line_number,
  input  logic                  item_valid,
  input  item_t                 item,
  output logic                  advance,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  typedef enum logic [2:0] {
    PH_NUM_HI,
    PH_NUM_LO,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            number_high, number_high_next;
  logic [7:0]            length_low, length_low_next;
  logic [BODY_LEN_W-1:0] body_left, body_left_next;
  logic [ERR_W-1:0]      first_error, first_error_next;
  logic [COUNT_W-1:0]    lines_seen, lines_seen_next;
  logic                  any_byte, any_byte_next;
  logic                  number_bad, number_bad_next;
  result_t               res_next;

  assign advance = !res_valid || res_ready;

  always_comb begin
    logic [LINE_NUM_W-1:0] line_num;
    logic [BODY_LEN_W-1:0] body_len;
    logic [BODY_LEN_W-1:0] body_dec;
    logic [ERR_W-1:0]      err;

    phase_next       = phase;
    number_high_next = number_high;
    length_low_next  = length_low;
    body_left_next   = body_left;
    first_error_next = first_error;
    lines_seen_next  = lines_seen;
    any_byte_next    = any_byte;
    number_bad_next  = number_bad;
    line_num = {number_high, item.data_byte};
    body_len = {item.data_byte, length_low};
    body_dec = (body_left != '0) ? body_left - 1'b1 : body_left;

    if (!item.no_data) begin
      any_byte_next = 1'b1;
      if (first_error == ERR_OK) begin
        case (phase)
          PH_NUM_HI: begin
            number_high_next = item.data_byte;
            phase_next       = PH_NUM_LO;
          end
          PH_NUM_LO: begin
            number_bad_next = (line_num == '0) || (line_num > max_line_number);
            phase_next      = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            length_low_next = item.data_byte;
            phase_next      = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (number_bad) begin
              first_error_next = ERR_BAD_NUMBER;
            end else if (body_len == '0) begin
              first_error_next = ERR_ZERO_LEN;
            end else begin
              body_left_next = body_len;
              phase_next     = PH_BODY;
            end
          end
          default: begin
            body_left_next = body_dec;
            if (body_dec == '0) begin
              if (item.data_byte != LINE_END) begin
                first_error_next = ERR_NO_TERM;
              end else begin
                if (lines_seen != '1) begin
                  lines_seen_next = lines_seen + 1'b1;
                end
                phase_next = PH_NUM_HI;
              end
            end
          end
        endcase
      end
    end

    err = first_error_next;
    if (err == ERR_OK) begin
      if (!any_byte_next) begin
        err = ERR_EMPTY;
      end else if (phase_next == PH_BODY) begin
        err = ERR_SHORT_BODY;
      end else if (phase_next != PH_NUM_HI) begin
        err = ERR_SHORT_HDR;
      end
    end
    res_next.valid_res  = (err == ERR_OK);
    res_next.error_kind = err;
    res_next.line_count = lines_seen_next;

    // end of stream: state returns to its cleared form
    if (item.last_byte) begin
      phase_next       = PH_NUM_HI;
      number_high_next = '0;
      length_low_next  = '0;
      body_left_next   = '0;
      first_error_next = ERR_OK;
      lines_seen_next  = '0;
      any_byte_next    = 1'b0;
      number_bad_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NUM_HI;
      number_high <= '0;
      length_low  <= '0;
      body_left   <= '0;
      first_error <= ERR_OK;
      lines_seen  <= '0;
      any_byte    <= 1'b0;
      number_bad  <= 1'b0;
      res_valid   <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid && item.last_byte;
      if (item_valid) begin
        phase       <= phase_next;
        number_high <= number_high_next;
        length_low  <= length_low_next;
        body_left   <= body_left_next;
        first_error <= first_error_next;
        lines_seen  <= lines_seen_next;
        any_byte    <= any_byte_next;
        number_bad  <= number_bad_next;
      end
    end
    if (advance && item_valid && item.last_byte) begin
      res <= res_next;
    end
  end

endmodule

FILE: design/blcc_checker.sv
module blcc_checker
  import blcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_verdict_matches_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ERR_OK)))
    else $error("valid_res disagrees with error_kind");

  a_kind_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:1] != 3'd7))
    else $error("error_kind out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:20] == 4'b0000))
    else $error("nonzero padding in result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind basic_line_chain_checker_top blcc_checker u_blcc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
